/* sv/temperature_to_segment_display_macros.svh */
// Assertion helpers shared by the top display module and tts_glyph.
// Both expect signals named clk and rst in the enclosing module.
`ifndef TEMPERATURE_TO_SEGMENT_DISPLAY_MACROS_SVH
`define TEMPERATURE_TO_SEGMENT_DISPLAY_MACROS_SVH

// Same-cycle implication.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tts_pkg.sv */
package tts_pkg;

  localparam int RAW_W      = 16;
  localparam int TENTHS_W   = 12;
  localparam int SHOWN_W    = 14;
  localparam int LIMIT_W    = 14;
  localparam int THR_W      = 12;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = 4;
  localparam int DIGIT_W    = 5;

  // tenths = trunc((SCALE_NUM * raw - OFFSET_NUM) / (10 * 2^16))
  localparam logic [14:0] SCALE_NUM  = 15'd17572;
  localparam logic [30:0] OFFSET_NUM = 31'd307036160;

  // Reciprocals for constant division, exact over the 14-bit range used here.
  localparam logic [15:0] RECIP_10   = 16'd52429;  // x/10   = (x * R) >> 19
  localparam logic [12:0] RECIP_100  = 13'd5243;   // x/100  = (x * R) >> 19
  localparam logic [13:0] RECIP_1000 = 14'd8389;   // x/1000 = (x * R) >> 23

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_THRESHOLD = 1'b1;

  localparam logic [LIMIT_W-1:0]      DISPLAY_LIMIT_RST = 14'd1258;
  localparam logic signed [THR_W-1:0] LED_THRESHOLD_RST = 12'sd300;

  typedef logic [7:0] glyph_t;

  typedef struct packed {
    logic                       valid;
    logic signed [TENTHS_W-1:0] tenths;
  } tenths_tok_t;

  typedef struct packed {
    logic               valid;
    logic [SHOWN_W-1:0] shown;
    logic               led;
  } shown_tok_t;

  typedef struct packed {
    logic               valid;
    logic [7:0]         row_a;
    logic [ROW_W-1:0]   row_b;
    logic [ROW_W-1:0]   row_c;
    logic [ROW_W-1:0]   row_d;
    logic [ROW_W-1:0]   row_e;
    logic [ROW_W-1:0]   row_f;
    logic [ROW_W-1:0]   row_g;
    logic [SHOWN_W-1:0] shown;
    logic               led;
  } result_t;

  // Bit s set lights segment s; digits above nine stay dark.
  function automatic glyph_t digit_glyph(input logic [DIGIT_W-1:0] digit);
    glyph_t g;
    unique case (digit)
      5'd0:    g = 8'h3F;
      5'd1:    g = 8'h06;
      5'd2:    g = 8'hDB;
      5'd3:    g = 8'hCF;
      5'd4:    g = 8'hE6;
      5'd5:    g = 8'hED;
      5'd6:    g = 8'hFD;
      5'd7:    g = 8'h07;
      5'd8:    g = 8'hFF;
      5'd9:    g = 8'hE7;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

/* sv/temperature_to_segment_display.sv */
// Pipeline: a transaction accepted at one edge shows its result, with done high, once it
// has passed every stage below; the receiver takes it at the edge ending the done cycle.
// Throughput: one transaction per cycle outside reset, set by the fully pipelined datapath
// (input register, three scaling stages, range check, two display stages).
// Reset (rst, synchronous): empties the pipeline, holds busy high, and loads
// display_limit = 1258 and led_threshold = 300. The receiver cannot stall done.
`include "temperature_to_segment_display_macros.svh"

module temperature_to_segment_display (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tts_pkg::RAW_W-1:0]        raw_code,
  input  logic                             cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output logic [7:0]                       row_a,
  output logic [tts_pkg::ROW_W-1:0]        row_b,
  output logic [tts_pkg::ROW_W-1:0]        row_c,
  output logic [tts_pkg::ROW_W-1:0]        row_d,
  output logic [tts_pkg::ROW_W-1:0]        row_e,
  output logic [tts_pkg::ROW_W-1:0]        row_f,
  output logic [tts_pkg::ROW_W-1:0]        row_g,
  output logic [tts_pkg::SHOWN_W-1:0]      shown_value,
  output logic                             led_on
);

  // Configuration registers.
  logic [tts_pkg::LIMIT_W-1:0]      display_limit;
  logic signed [tts_pkg::THR_W-1:0] led_threshold;

  logic                 accept;
  tts_pkg::tenths_tok_t tenths_tok;
  tts_pkg::shown_tok_t  shown_tok;
  tts_pkg::shown_tok_t  shown_tok_next;
  tts_pkg::result_t     result;
  logic                 in_range;

  // The pipeline never backs up; hold off only while in reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // Register writes take effect at once; an out-of-range index cannot occur.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_limit <= tts_pkg::DISPLAY_LIMIT_RST;
      led_threshold <= tts_pkg::LED_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tts_pkg::REG_DISPLAY_LIMIT: display_limit <= cfg_data;
        tts_pkg::REG_LED_THRESHOLD: led_threshold <= $signed(cfg_data[tts_pkg::THR_W-1:0]);
      endcase
    end
  end

  // Raw code to signed tenths of a degree.
  tts_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .raw_code   (raw_code),
    .tenths_tok (tenths_tok)
  );

  // Range check: show zero for negative values or values past the limit.
  // The LED compares the unclamped signed value against the threshold.
  always_comb begin
    in_range = !tenths_tok.tenths[tts_pkg::TENTHS_W-1] &&
               ({3'b000, tenths_tok.tenths[tts_pkg::TENTHS_W-2:0]} <= display_limit);
    shown_tok_next.valid = tenths_tok.valid;
    shown_tok_next.led   = tenths_tok.tenths >= led_threshold;
    if (in_range) begin
      shown_tok_next.shown = {3'b000, tenths_tok.tenths[tts_pkg::TENTHS_W-2:0]};
    end else begin
      shown_tok_next.shown = '0;
    end
  end

  // Hold the checked value for the display stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_tok.valid <= 1'b0;
    end else begin
      shown_tok.valid <= shown_tok_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    shown_tok.shown <= shown_tok_next.shown;
    shown_tok.led   <= shown_tok_next.led;
  end

  // Split into digits and map to segment rows.
  tts_glyph u_glyph (
    .clk       (clk),
    .rst       (rst),
    .shown_tok (shown_tok),
    .result    (result)
  );

  // Drive the result ports straight from the result register.
  assign done        = result.valid;
  assign row_a       = result.row_a;
  assign row_b       = result.row_b;
  assign row_c       = result.row_c;
  assign row_d       = result.row_d;
  assign row_e       = result.row_e;
  assign row_f       = result.row_f;
  assign row_g       = result.row_g;
  assign shown_value = result.shown;
  assign led_on      = result.led;

  `TTS_ASSERT_NOW(a_accept_to_done, accept, ##7 done, "accepted transaction produced no result")
  `TTS_ASSERT_NOW(a_done_has_source, done, $past(accept, 7), "result without a transaction")
  `TTS_ASSERT_NOW(a_shown_in_limit, done && (shown_value != '0), shown_value <= display_limit,
                  "shown value above display limit")

endmodule

/* sv/tts_scale.sv */
module tts_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [tts_pkg::RAW_W-1:0]    raw_code,
  output tts_pkg::tenths_tok_t         tenths_tok
);

  logic                      in_valid;
  logic [tts_pkg::RAW_W-1:0] in_raw;

  logic        prod_valid;
  logic [30:0] prod;
  logic [30:0] prod_next;

  logic        mag_valid;
  logic        mag_neg;
  logic [13:0] mag_hi;
  logic        mag_neg_next;
  logic [30:0] diff;

  logic [29:0]                  qprod;
  logic [10:0]                  quot;
  logic [tts_pkg::TENTHS_W-1:0] quot_ext;
  tts_pkg::tenths_tok_t         tenths_tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
      mag_valid  <= 1'b0;
      tenths_tok.valid <= 1'b0;
    end else begin
      in_valid   <= accept;
      prod_valid <= in_valid;
      mag_valid  <= prod_valid;
      tenths_tok.valid <= tenths_tok_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    in_raw  <= raw_code;
    prod    <= prod_next;
    mag_neg <= mag_neg_next;
    mag_hi  <= diff[29:16];
    tenths_tok.tenths <= tenths_tok_next.tenths;
  end

  // Scale the raw code.
  assign prod_next = {15'd0, in_raw} * {16'd0, tts_pkg::SCALE_NUM};

  // Remove the offset as a sign and magnitude; drop the 2^16 part of the divisor.
  always_comb begin
    mag_neg_next = prod < tts_pkg::OFFSET_NUM;
    if (mag_neg_next) begin
      diff = tts_pkg::OFFSET_NUM - prod;
    end else begin
      diff = prod - tts_pkg::OFFSET_NUM;
    end
  end

  // Divide the magnitude by ten, then restore the sign (truncates toward zero).
  always_comb begin
    qprod    = {16'd0, mag_hi} * {14'd0, tts_pkg::RECIP_10};
    quot     = qprod[29:19];
    quot_ext = {1'b0, quot};
    tenths_tok_next.valid = mag_valid;
    if (mag_neg) begin
      tenths_tok_next.tenths = $signed(~quot_ext + 12'd1);
    end else begin
      tenths_tok_next.tenths = $signed(quot_ext);
    end
  end

endmodule

/* sv/tts_glyph.sv */
`include "temperature_to_segment_display_macros.svh"

module tts_glyph (
  input  logic                clk,
  input  logic                rst,
  input  tts_pkg::shown_tok_t shown_tok,
  output tts_pkg::result_t    result
);

  logic                        e_valid;
  logic [tts_pkg::SHOWN_W-1:0] e_value;
  logic                        e_led;
  logic [4:0]                  e_q1000;
  logic [7:0]                  e_q100;
  logic [10:0]                 e_q10;

  logic [27:0] p1000;
  logic [26:0] p100;
  logic [29:0] p10;

  logic [7:0]                  hu_full;
  logic [10:0]                 te_full;
  logic [tts_pkg::SHOWN_W-1:0] on_full;
  logic [3:0][tts_pkg::DIGIT_W-1:0] digit;
  logic [3:0][7:0]             glyph;
  logic [7:0][3:0]             seg;
  tts_pkg::result_t            result_next;

  // Stage E: quotients by 1000, 100 and 10 in parallel.
  always_comb begin
    p1000 = {14'd0, shown_tok.shown} * {14'd0, tts_pkg::RECIP_1000};
    p100  = {13'd0, shown_tok.shown} * {14'd0, tts_pkg::RECIP_100};
    p10   = {16'd0, shown_tok.shown} * {14'd0, tts_pkg::RECIP_10};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      e_valid      <= shown_tok.valid;
      result.valid <= result_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    e_value <= shown_tok.shown;
    e_led   <= shown_tok.led;
    e_q1000 <= p1000[27:23];
    e_q100  <= p100[26:19];
    e_q10   <= p10[29:19];
    result.row_a <= result_next.row_a;
    result.row_b <= result_next.row_b;
    result.row_c <= result_next.row_c;
    result.row_d <= result_next.row_d;
    result.row_e <= result_next.row_e;
    result.row_f <= result_next.row_f;
    result.row_g <= result_next.row_g;
    result.shown <= result_next.shown;
    result.led   <= result_next.led;
  end

  // Stage F: digits from neighboring quotients, then glyphs into rows.
  always_comb begin
    hu_full = e_q100 - ({e_q1000, 3'b000} + {2'b00, e_q1000, 1'b0});
    te_full = e_q10 - ({e_q100, 3'b000} + {2'b00, e_q100, 1'b0});
    on_full = e_value - ({e_q10, 3'b000} + {2'b00, e_q10, 1'b0});
    digit[0] = e_q1000;
    digit[1] = hu_full[tts_pkg::DIGIT_W-1:0];
    digit[2] = te_full[tts_pkg::DIGIT_W-1:0];
    digit[3] = on_full[tts_pkg::DIGIT_W-1:0];
    for (int p = 0; p < 4; p++) begin
      glyph[p] = tts_pkg::digit_glyph(digit[p]);
    end
    for (int s = 0; s < 8; s++) begin
      for (int p = 0; p < 4; p++) begin
        seg[s][p] = glyph[p][s];
      end
    end
    result_next.valid = e_valid;
    result_next.row_a = {seg[7], seg[0]};
    result_next.row_b = seg[1];
    result_next.row_c = seg[2];
    result_next.row_d = seg[3];
    result_next.row_e = seg[4];
    result_next.row_f = seg[5];
    result_next.row_g = seg[6];
    result_next.shown = e_value;
    result_next.led   = e_led;
  end

  `TTS_ASSERT_NOW(a_hundreds_digit, e_valid, hu_full < 8'd10, "hundreds digit out of range")
  `TTS_ASSERT_NOW(a_tens_digit, e_valid, te_full < 11'd10, "tens digit out of range")
  `TTS_ASSERT_NOW(a_ones_digit, e_valid, on_full < 14'd10, "ones digit out of range")
  `TTS_ASSERT_NEXT(a_result_follows, e_valid, result.valid, "stage F lost a transaction")

endmodule
